[hdl/hrld_pkg.sv]
// Shared constants, types and decode functions of the hex run-length decoder.
package hrld_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_SYM_LO  = 8'h47;  // 'G'
  localparam logic [7:0] CHAR_SYM_HI  = 8'h4E;  // 'N'
  localparam logic [4:0] HEX_RADIX_SHIFT = 5'd4;  // one hex digit is four bits (radix 16)

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [7:0] ROW_WIDTH_RESET = 8'd16;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CHAR_ZERO);
    end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CHAR_UPPER_A + 8'd10);
    end
    return h;
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    return (b >= CHAR_SYM_LO) && (b <= CHAR_SYM_HI);
  endfunction

endpackage

[hdl/hrld_if.sv]
// Valid/ready channel interfaces for the encoded byte input and the symbol output.
interface hrld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hrld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] symbol_digit;
  logic       row_break;
  logic       run_last;

  modport source (output valid, output symbol_digit, output row_break, output run_last,
                  input ready);
  modport sink (input valid, input symbol_digit, input row_break, input run_last,
                output ready);
endinterface

[hdl/hrld_front.sv]
// Front end: accepts encoded bytes, builds the repeat count and queues run commands.
module hrld_front #(
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned CNT_W   = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  hrld_in_if.sink            in_chan,
  input  logic               q_full,
  output logic               q_push,
  output logic [CNT_W+2:0]   q_wdata
);

  localparam int unsigned NXT_W = CNT_W + 4;

  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic             active_r, active_nxt;
  logic             accept;
  hrld_pkg::hex_t   hex;
  logic             sym;
  logic [NXT_W-1:0] acc;
  logic [CNT_W-1:0] run_len;
  logic [2:0]       digit;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign hex           = hrld_pkg::hex_decode(in_chan.in_byte);
  assign sym           = hrld_pkg::is_symbol(in_chan.in_byte);
  assign digit         = 3'(in_chan.in_byte - hrld_pkg::CHAR_SYM_LO);

  always_comb begin
    acc = active_r ? ((NXT_W'(pend_r) << hrld_pkg::HEX_RADIX_SHIFT) | NXT_W'(hex.val))
                   : NXT_W'(hex.val);
    run_len = active_r ? pend_r : CNT_W'(1);
    pend_nxt   = pend_r;
    active_nxt = active_r;
    q_push     = 1'b0;
    if (accept) begin
      if (hex.ok) begin
        // The count saturates; further digits leave it at the ceiling.
        pend_nxt   = (acc > NXT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : acc[CNT_W-1:0];
        active_nxt = 1'b1;
      end else begin
        pend_nxt   = '0;
        active_nxt = 1'b0;
        q_push     = sym && (run_len != '0);
      end
    end
  end

  assign q_wdata = {digit, run_len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      active_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      active_r <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CNT_W'(MAX_RUN))
    else $error("pending count above ceiling");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");
  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !active_r && pend_r == '0)
    else $error("count not cleared after a run");
`endif

endmodule

[hdl/hrld_fifo.sv]
// Short command queue between the front end and the symbol emitter.
module hrld_fifo #(
  parameter int unsigned WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]            mem_r [hrld_pkg::FIFO_DEPTH];
  logic [hrld_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [hrld_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (hrld_pkg::FIFO_AW+1)'(hrld_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == cnt_r[hrld_pkg::FIFO_AW-1:0])
    else $error("queue pointers disagree with fill count");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (hrld_pkg::FIFO_AW+1)'(hrld_pkg::FIFO_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

[hdl/hrld_back.sv]
// Back end: expands queued runs into symbols, tracks the column and drives the output register.
module hrld_back #(
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       row_width,
  input  logic             q_empty,
  input  logic [CNT_W+2:0] q_rdata,
  output logic             q_pop,
  hrld_out_if.source       out_chan
);

  logic             busy_r, busy_nxt;
  logic [2:0]       digit_r, digit_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [7:0]       col_r, col_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [2:0]       odigit_r, odigit_nxt;
  logic             obrk_r, obrk_nxt;
  logic             olast_r, olast_nxt;
  logic             advance;
  logic             last;
  logic [8:0]       col_inc;
  logic             brk;

  assign advance = busy_r && (!ovalid_r || out_chan.ready);
  assign last    = (remain_r == CNT_W'(1));
  assign col_inc = {1'b0, col_r} + 9'd1;
  assign brk     = (col_inc >= {1'b0, row_width});
  assign q_pop   = !q_empty && (!busy_r || (advance && last));

  always_comb begin
    busy_nxt   = busy_r;
    digit_nxt  = digit_r;
    remain_nxt = remain_r;
    col_nxt    = col_r;
    ovalid_nxt = ovalid_r && !out_chan.ready;
    odigit_nxt = odigit_r;
    obrk_nxt   = obrk_r;
    olast_nxt  = olast_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      odigit_nxt = digit_r;
      obrk_nxt   = brk;
      olast_nxt  = last;
      col_nxt    = brk ? 8'd0 : col_inc[7:0];
      remain_nxt = remain_r - 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt   = 1'b1;
      digit_nxt  = q_rdata[CNT_W+2:CNT_W];
      remain_nxt = q_rdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      col_r    <= 8'd0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      col_r    <= col_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r  <= digit_nxt;
    remain_r <= remain_nxt;
    odigit_r <= odigit_nxt;
    obrk_r   <= obrk_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_chan.valid        = ovalid_r;
  assign out_chan.symbol_digit = odigit_r;
  assign out_chan.row_break    = obrk_r;
  assign out_chan.run_last     = olast_r;

`ifndef SYNTHESIS
  a_busy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> remain_r != '0)
    else $error("emitter busy with nothing left to send");
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ovalid_r)
    else $error("emitted symbol not registered");
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last && !q_pop) |=> !busy_r)
    else $error("emitter still busy after final symbol");
`endif

endmodule

[hdl/hex_run_length_decoder.sv]
// Hex run-length decoder: top level with configuration register and front/back split.
//
// Usage: encoded ASCII bytes arrive on in_chan (valid/ready). Uppercase hex digits
// build a repeat count that saturates at MAX_RUN; a letter G to N then emits digit
// 0 to 7 on out_chan, once without a count or count times with one. Each symbol
// carries run_last on the final one of its byte and row_break every row_width symbols.
// The row_width register sits at byte address 0 of the APB port (reset 16); the user
// must write it only while the decoder is idle: the block does not enforce this.
// A run byte passes through the run queue, the emitter's run registers and the output
// register before its first symbol shows; the emitter then produces one symbol a
// cycle unless out_chan stalls. Digit and other bytes are taken one a cycle while
// the four-entry run queue has room; in_chan.ready drops only when that queue is full.
// A stalled out_chan holds the current word and the emitter waits; the front end
// keeps taking bytes until the queue fills. Reset (rst_n low, synchronous) clears the
// count, the column, the queue and the output register.
module hex_run_length_decoder #(
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hrld_in_if.sink                       in_chan,
  hrld_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrld_pkg::PADDR_W-1:0]  paddr,
  input  logic [hrld_pkg::PDATA_W-1:0]  pwdata,
  output logic [hrld_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);
  localparam int unsigned CMD_W = CNT_W + 3;

  logic [7:0]       row_width_r, row_width_nxt;
  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == hrld_pkg::REG_ROW_WIDTH)
                  ? {{(hrld_pkg::PDATA_W-8){1'b0}}, row_width_r} : '0;

  always_comb begin
    row_width_nxt = row_width_r;
    if (psel && penable && pwrite && (paddr == hrld_pkg::REG_ROW_WIDTH)) begin
      row_width_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= hrld_pkg::ROW_WIDTH_RESET;
    end else begin
      row_width_r <= row_width_nxt;
    end
  end

  hrld_front #(
    .MAX_RUN (MAX_RUN),
    .CNT_W   (CNT_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  hrld_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hrld_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_width (row_width_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

[verif/tb_hex_run_length_decoder.sv]
// Self-checking testbench of the hex run-length decoder: directed table, random runs, row widths.
`timescale 1ns / 100ps

module tb_hex_run_length_decoder;

  localparam int unsigned RUN_CAP      = 64;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          BURST_ITEMS  = 68;

  typedef struct packed {
    logic [2:0] digit;
    logic       brk;
    logic       last;
  } sym_t;

  // One row of the directed table: when typed is set, the expected word is written here
  // (one symbol when emits is set, nothing otherwise) rather than taken from the predictor.
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic       emits;
    logic [2:0] digit;
    logic       brk;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  hrld_in_if  in_chan ();
  hrld_out_if out_chan ();

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [hrld_pkg::PADDR_W-1:0]   paddr;
  logic [hrld_pkg::PDATA_W-1:0]   pwdata;
  logic [hrld_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  hex_run_length_decoder #(.MAX_RUN(RUN_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [6:0] run_count;
  logic       run_count_live;
  logic [8:0] column;
  logic [7:0] row_width_now;

  sym_t due_symbols[$];
  sym_t fresh_symbols[$];

  int bad_count     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_seen    = 0;
  int hold_left     = 0;

  row_t directed_rows [25];

  task automatic report_bad(input string what, input logic [31:0] want, input logic [31:0] got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Works out the symbols that one accepted byte gives, into fresh_symbols.
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned nibble;
    int unsigned acc;
    int unsigned reps;
    logic        is_hex;
    sym_t        s;
    fresh_symbols.delete();
    is_hex = 1'b1;
    nibble = 0;
    if (b >= hrld_pkg::CHAR_ZERO && b <= hrld_pkg::CHAR_NINE) begin
      nibble = 32'(b - hrld_pkg::CHAR_ZERO);
    end else if (b >= hrld_pkg::CHAR_UPPER_A && b <= hrld_pkg::CHAR_UPPER_F) begin
      nibble = b - hrld_pkg::CHAR_UPPER_A + 10;
    end else begin
      is_hex = 1'b0;
    end
    if (is_hex) begin
      acc = run_count_live ? run_count * 16 + nibble : nibble;
      if (acc > RUN_CAP) begin
        acc = RUN_CAP;
      end
      run_count      = acc[6:0];
      run_count_live = 1'b1;
    end else if (b >= hrld_pkg::CHAR_SYM_LO && b <= hrld_pkg::CHAR_SYM_HI) begin
      reps = run_count_live ? run_count : 1;
      if (reps > RUN_CAP) begin
        reps = RUN_CAP;
      end
      run_count      = '0;
      run_count_live = 1'b0;
      for (int i = 0; i < reps; i++) begin
        column  = column + 9'd1;
        s.digit = 3'(b - hrld_pkg::CHAR_SYM_LO);
        s.brk   = (column >= {1'b0, row_width_now});
        s.last  = (i + 1 == reps);
        if (s.brk) begin
          column = '0;
        end
        fresh_symbols.push_back(s);
      end
    end else begin
      run_count      = '0;
      run_count_live = 1'b0;
    end
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    return (v < 10) ? hrld_pkg::CHAR_ZERO + 8'(v) : hrld_pkg::CHAR_UPPER_A + 8'(v - 10);
  endfunction

  function automatic logic [7:0] symbol_char();
    return hrld_pkg::CHAR_SYM_LO + 8'($urandom_range(7));
  endfunction

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic emits,
                           input sym_t typed_sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    decode_byte(b);
    if (typed) begin
      if (emits) begin
        due_symbols.push_back(typed_sym);
      end
    end else begin
      foreach (fresh_symbols[k]) due_symbols.push_back(fresh_symbols[k]);
    end
    @(negedge clk);
  endtask

  // Mostly well-formed runs with random counts and symbols, plus stray and broken bytes.
  task automatic random_burst(input int n_items);
    logic [7:0] seq[$];
    int         sent;
    int         kind;
    int         pick;
    sent = 0;
    while (sent < n_items) begin
      seq.delete();
      kind = $urandom_range(99);
      if (kind < 50) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          seq.push_back(hex_char($urandom_range(15)));
        end else if (pick < 75) begin
          seq.push_back(hex_char($urandom_range(3)));
          seq.push_back(hex_char($urandom_range(15)));
        end else if (pick < 85) begin
          seq.push_back(hex_char(4));
          seq.push_back(hex_char($urandom_range(15)));
        end else begin
          repeat (3) seq.push_back(hex_char($urandom_range(15)));
        end
        seq.push_back(symbol_char());
      end else if (kind < 65) begin
        seq.push_back(symbol_char());
      end else if (kind < 80) begin
        seq.push_back(8'($urandom_range(255)));
      end else begin
        seq.push_back(hex_char($urandom_range(1, 15)));
        seq.push_back((kind < 90) ? 8'h20 : 8'($urandom_range(8'h61, 8'h7A)));
        seq.push_back(symbol_char());
      end
      foreach (seq[k]) send_byte(seq[k], 1'b0, 1'b0, '0);
      sent += seq.size();
    end
  endtask

  // Lets the decoder run dry: every due symbol out, then time for queued count bytes.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (due_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Reads the row width back; leaves the port idle at a falling edge.
  task automatic check_row_width(input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= hrld_pkg::REG_ROW_WIDTH;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, want}) begin
      report_bad("row_width readback", {24'b0, want}, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_row_width(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hrld_pkg::REG_ROW_WIDTH;
    pwdata  <= {24'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    row_width_now = v;
    @(negedge clk);
    check_row_width(v);
  endtask

  // Receiver: random stalls, and on request one long hold-off so the run queue fills.
  always @(negedge clk) begin
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sym_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_symbols.size() == 0) begin
        report_bad("word with nothing due", 32'h0,
                   {27'b0, out_chan.symbol_digit, out_chan.row_break, out_chan.run_last});
      end else begin
        want = due_symbols.pop_front();
        if (out_chan.symbol_digit !== want.digit) begin
          report_bad("symbol_digit", 32'(want.digit), 32'(out_chan.symbol_digit));
        end
        if (out_chan.row_break !== want.brk) begin
          report_bad("row_break", 32'(want.brk), 32'(out_chan.row_break));
        end
        if (out_chan.run_last !== want.last) begin
          report_bad("run_last", 32'(want.last), 32'(out_chan.run_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] widths [6];
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = 8'h00;
    out_chan.ready  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    run_count       = '0;
    run_count_live  = 1'b0;
    column          = '0;
    row_width_now   = hrld_pkg::ROW_WIDTH_RESET;

    directed_rows = '{
      '{hrld_pkg::CHAR_SYM_LO, 1'b1, 1'b1, 3'd0, 1'b0},  // G alone
      '{hrld_pkg::CHAR_SYM_HI, 1'b1, 1'b1, 3'd7, 1'b0},  // N alone
      '{8'h00,       1'b1, 1'b0, 3'd0, 1'b0},
      '{8'hFF,       1'b1, 1'b0, 3'd0, 1'b0},
      '{8'h33,       1'b1, 1'b0, 3'd0, 1'b0},  // '3'
      '{8'h48,       1'b0, 1'b0, 3'd0, 1'b0},  // 'H' three times
      '{8'h30,       1'b1, 1'b0, 3'd0, 1'b0},  // '0'
      '{8'h49,       1'b1, 1'b0, 3'd0, 1'b0},  // 'I' after a zero count
      '{8'h39,       1'b1, 1'b0, 3'd0, 1'b0},  // '9'
      '{8'h46,       1'b1, 1'b0, 3'd0, 1'b0},  // 'F' saturates
      '{8'h41,       1'b1, 1'b0, 3'd0, 1'b0},  // 'A' stays saturated
      '{8'h4D,       1'b0, 1'b0, 3'd0, 1'b0},  // 'M' full run
      '{8'h35,       1'b1, 1'b0, 3'd0, 1'b0},  // '5'
      '{8'h20,       1'b1, 1'b0, 3'd0, 1'b0},  // space drops the count
      '{8'h4A,       1'b0, 1'b0, 3'd0, 1'b0},  // 'J' once
      '{8'h2F,       1'b1, 1'b0, 3'd0, 1'b0},  // just below '0'
      '{8'h3A,       1'b1, 1'b0, 3'd0, 1'b0},  // just above '9'
      '{8'h40,       1'b1, 1'b0, 3'd0, 1'b0},  // just below 'A'
      '{8'h4F,       1'b1, 1'b0, 3'd0, 1'b0},  // just above 'N'
      '{8'h61,       1'b1, 1'b0, 3'd0, 1'b0},  // lowercase
      '{8'h34,       1'b1, 1'b0, 3'd0, 1'b0},  // '4'
      '{8'h30,       1'b1, 1'b0, 3'd0, 1'b0},  // '0', exactly the cap
      '{8'h4B,       1'b0, 1'b0, 3'd0, 1'b0},  // 'K'
      '{8'h46,       1'b1, 1'b0, 3'd0, 1'b0},  // 'F'
      '{8'h4C,       1'b0, 1'b0, 3'd0, 1'b0}   // 'L' fifteen times
    };

    // The lowered width follows the widest, so the column may already be past it.
    widths = '{hrld_pkg::ROW_WIDTH_RESET, 8'd1, 8'd255, 8'd5, 8'd0,
               8'($urandom_range(2, 254))};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 48;
    check_row_width(hrld_pkg::ROW_WIDTH_RESET);
    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].code, directed_rows[r].typed, directed_rows[r].emits,
                '{directed_rows[r].digit, directed_rows[r].brk, 1'b1});
    end
    random_burst(BURST_ITEMS);

    for (int phase = 1; phase < 6; phase++) begin
      settle();
      if (phase == 2) begin
        send_idle_pct = 48;
        recv_idle_pct = 30;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_row_width(widths[phase]);
      if (phase == 1) begin
        holds_asked++;
      end
      random_burst(BURST_ITEMS);
    end

    settle();
    if (bad_count == 0 && due_symbols.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
